@@ rtl/core/smsd_pkg.sv @@
package smsd_pkg;

    localparam int CFG_W   = 7;
    localparam int COUNT_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Step control broadcast to every cell of both rows
    typedef struct packed {
        logic load;     // a sample transfer happens this cycle
        logic rem_en;   // window is full: the oldest sample leaves
    } t_step_ctl;

endpackage

@@ rtl/core/smsd_ring_cell.sv @@
module smsd_ring_cell
    import smsd_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  t_step_ctl              i_ctl,
    input  logic [SAMPLE_BITS-1:0] i_prev,
    input  logic                   i_sel,
    output logic [SAMPLE_BITS-1:0] o_val,
    output logic [SAMPLE_BITS-1:0] o_pick
);

    logic [SAMPLE_BITS-1:0] r_val;

    // advance the arrival line by one tap per transfer
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_val <= i_prev;
        end
    end

    assign o_val  = r_val;
    assign o_pick = i_sel ? r_val : '0;

endmodule

@@ rtl/core/smsd_sort_cell.sv @@
module smsd_sort_cell
    import smsd_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int LEN_W       = 7,
    parameter int CELL_IDX    = 0
) (
    input  logic                   i_clk,
    input  t_step_ctl              i_ctl,
    input  logic [LEN_W-1:0]       i_keep_cnt,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [SAMPLE_BITS-1:0] i_oldest,
    input  logic [SAMPLE_BITS-1:0] i_right_val,
    input  logic [SAMPLE_BITS-1:0] i_left_w,
    input  logic                   i_left_le,
    input  logic                   i_sel_lo,
    input  logic                   i_sel_hi,
    output logic [SAMPLE_BITS-1:0] o_w,
    output logic                   o_le,
    output logic [SAMPLE_BITS-1:0] o_val,
    output logic [SAMPLE_BITS-1:0] o_lo,
    output logic [SAMPLE_BITS-1:0] o_hi
);

    logic [SAMPLE_BITS-1:0] r_val;
    logic [SAMPLE_BITS-1:0] n_val;
    logic                   in_win;

    // Entries at or past the first copy of the oldest value close the gap
    assign o_w    = (i_ctl.rem_en && (r_val >= i_oldest)) ? i_right_val : r_val;
    assign in_win = LEN_W'(CELL_IDX) < i_keep_cnt;
    assign o_le   = in_win && (o_w <= i_sample);

    // keep, take the new sample, or take the left neighbor's survivor
    always_comb begin
        priority if (o_le) begin
            n_val = o_w;
        end else if (i_left_le) begin
            n_val = i_sample;
        end else begin
            n_val = i_left_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;
    assign o_lo  = i_sel_lo ? r_val : '0;
    assign o_hi  = i_sel_hi ? r_val : '0;

endmodule

@@ rtl/core/sliding_median_spike_detector.sv @@
// Sliding-window median spike detector. Each transferred sample is compared
// with twice the median of the previous window_length samples (sum of the two
// middle entries for an even length, double the middle one for an odd length)
// and a sample at or above that level sets spike_flag and bumps a saturating
// 32-bit count. Until the window has filled, samples are only loaded and the
// result shows window_full, twice_median and spike_flag as zero. The window
// lives in a row of WINDOW_MAX sorted cells next to a row of arrival-order
// taps; each transfer inserts the new sample across the whole row and, when
// the window is full, removes the oldest, so the block takes one sample per
// cycle unless o_stall is high; the result is loaded into the output register.
// Writing window_length (0 acts as 1, values above WINDOW_MAX act as
// WINDOW_MAX) empties the window and keeps the count; write it only while idle.
module sliding_median_spike_detector
    import smsd_pkg::*;
#(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_W-1:0]       i_cfg_data,
    // sample input
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [SAMPLE_BITS-1:0] i_sample_value,
    // result output
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_window_full,
    output logic [SAMPLE_BITS:0]   o_twice_median,
    output logic                   o_spike_flag,
    output logic [COUNT_W-1:0]     o_spike_count
);

    localparam int LEN_W = $clog2(WINDOW_MAX + 1);

    logic [LEN_W-1:0]       r_win_len;
    logic [LEN_W-1:0]       n_win_len;
    logic [LEN_W-1:0]       r_fill;
    logic [COUNT_W-1:0]     r_count;
    logic [COUNT_W-1:0]     n_count;
    logic                   r_out_valid;
    logic                   r_window_full;
    logic [SAMPLE_BITS:0]   r_twice_median;
    logic                   r_spike_flag;
    logic [COUNT_W-1:0]     r_spike_count;

    logic                   accept;
    logic                   full;
    logic                   spike;
    t_step_ctl              ctl;
    logic [LEN_W-1:0]       keep_cnt;
    logic [LEN_W-1:0]       mid_hi;
    logic [LEN_W-1:0]       mid_lo;
    logic [LEN_W-1:0]       last_tap;
    logic [SAMPLE_BITS-1:0] oldest;
    logic [SAMPLE_BITS-1:0] med_lo;
    logic [SAMPLE_BITS-1:0] med_hi;
    logic [SAMPLE_BITS:0]   twice;

    logic [SAMPLE_BITS-1:0] sort_val  [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] sort_w    [WINDOW_MAX];
    logic                   sort_le   [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] sort_lo   [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] sort_hi   [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] ring_val  [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] ring_pick [WINDOW_MAX];

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_out_valid && i_stall;
    assign accept      = i_valid && !o_stall;

    assign full        = (r_fill == r_win_len);
    assign ctl.load    = accept;
    assign ctl.rem_en  = full;
    assign keep_cnt    = full ? (r_win_len - LEN_W'(1)) : r_fill;
    assign mid_hi      = r_win_len >> 1;
    assign mid_lo      = r_win_len[0] ? mid_hi : (mid_hi - LEN_W'(1));
    assign last_tap    = r_win_len - LEN_W'(1);

    // clamp the written length into 1..WINDOW_MAX
    always_comb begin
        priority if (32'(i_cfg_data) > WINDOW_MAX) begin
            n_win_len = LEN_W'(WINDOW_MAX);
        end else if (i_cfg_data == '0) begin
            n_win_len = LEN_W'(1);
        end else begin
            n_win_len = LEN_W'(i_cfg_data);
        end
    end

    genvar k;
    generate
        for (k = 0; k < WINDOW_MAX; k++) begin : g_cell
            logic [SAMPLE_BITS-1:0] right_val;
            logic [SAMPLE_BITS-1:0] left_w;
            logic                   left_le;
            logic [SAMPLE_BITS-1:0] ring_prev;

            if (k == WINDOW_MAX - 1) begin : g_last
                assign right_val = '0;
            end else begin : g_mid
                assign right_val = sort_val[k+1];
            end

            if (k == 0) begin : g_head
                assign left_w    = i_sample_value;
                assign left_le   = 1'b1;
                assign ring_prev = i_sample_value;
            end else begin : g_body
                assign left_w    = sort_w[k-1];
                assign left_le   = sort_le[k-1];
                assign ring_prev = ring_val[k-1];
            end

            smsd_sort_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .LEN_W       (LEN_W),
                .CELL_IDX    (k)
            ) u_sort (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_keep_cnt  (keep_cnt),
                .i_sample    (i_sample_value),
                .i_oldest    (oldest),
                .i_right_val (right_val),
                .i_left_w    (left_w),
                .i_left_le   (left_le),
                .i_sel_lo    (LEN_W'(k) == mid_lo),
                .i_sel_hi    (LEN_W'(k) == mid_hi),
                .o_w         (sort_w[k]),
                .o_le        (sort_le[k]),
                .o_val       (sort_val[k]),
                .o_lo        (sort_lo[k]),
                .o_hi        (sort_hi[k])
            );

            smsd_ring_cell #(
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_ring (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_prev      (ring_prev),
                .i_sel       (LEN_W'(k) == last_tap),
                .o_val       (ring_val[k]),
                .o_pick      (ring_pick[k])
            );
        end
    endgenerate

    // one-hot picks: only the selected cell drives nonzero
    always_comb begin
        oldest = '0;
        med_lo = '0;
        med_hi = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            oldest = oldest | ring_pick[i];
            med_lo = med_lo | sort_lo[i];
            med_hi = med_hi | sort_hi[i];
        end
    end

    assign twice = {1'b0, med_lo} + {1'b0, med_hi};
    assign spike = full && ({1'b0, i_sample_value} >= twice);

    always_comb begin
        n_count = r_count;
        if (spike && (r_count != COUNT_MAX)) begin
            n_count = r_count + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len   <= LEN_W'(1);
            r_fill      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_win_len <= n_win_len;
                r_fill    <= '0;
            end else if (accept && !full) begin
                r_fill <= r_fill + LEN_W'(1);
            end
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the result until the transfer on the output side
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_window_full  <= full;
            r_twice_median <= full ? twice : '0;
            r_spike_flag   <= spike;
            r_spike_count  <= n_count;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_window_full  = r_window_full;
    assign o_twice_median = r_twice_median;
    assign o_spike_flag   = r_spike_flag;
    assign o_spike_count  = r_spike_count;

`ifndef ASSERT_OFF
    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_win_len)
        else $error("fill level exceeds window length");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_win_len != '0) && (32'(r_win_len) <= WINDOW_MAX))
        else $error("window length out of range");

    a_count_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_count >= $past(r_count)))
        else $error("spike count decreased");

    a_flag_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_spike_flag) |-> o_window_full)
        else $error("spike flagged before window filled");

    a_filling_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_window_full) |-> (o_twice_median == '0))
        else $error("threshold shown while window filling");
`endif

endmodule

@@ tb/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import smsd_pkg::*;

    localparam int WMAX         = 64;
    localparam int SBITS        = 16;
    localparam int ITEM_TARGET  = 1800;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 4000;

    typedef struct packed {
        logic               full;
        logic [SBITS:0]     twice;
        logic               spike;
        logic [COUNT_W-1:0] count;
    } t_detect;

    typedef enum logic {ROW_SAMPLE, ROW_LENGTH} t_row_kind;

    typedef struct {
        t_row_kind        kind;
        logic [SBITS-1:0] value;
        bit               typed;
        t_detect          exp;
    } t_stim_row;

    typedef struct {
        bit      typed;
        t_detect exp;
    } t_sample_tag;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [SBITS-1:0]   i_sample_value = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_window_full;
    logic [SBITS:0]     o_twice_median;
    logic               o_spike_flag;
    logic [COUNT_W-1:0] o_spike_count;

    sliding_median_spike_detector #(
        .WINDOW_MAX  (WMAX),
        .SAMPLE_BITS (SBITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample_value (i_sample_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_window_full  (o_window_full),
        .o_twice_median (o_twice_median),
        .o_spike_flag   (o_spike_flag),
        .o_spike_count  (o_spike_count)
    );

    always #5 i_clk = ~i_clk;

    // window predictor state
    logic [SBITS-1:0]   ordered_win  [WMAX];
    logic [SBITS-1:0]   arrival_hist [WMAX];
    int                 head_idx = 0;
    int                 fill_cnt = 0;
    logic [CFG_W-1:0]   len_reg = 7'd1;
    logic [COUNT_W-1:0] spike_total = '0;

    t_detect     pending_results [$];
    t_sample_tag sample_tags [$];
    t_stim_row   stim_rows [$];

    int  err_cnt = 0;
    int  n_sent = 0;
    int  n_accepted = 0;
    int  n_results = 0;
    int  n_compared = 0;
    int  n_spikes = 0;
    int  n_len_writes = 0;
    int  n_in_stalls = 0;
    int  quiet_cycles = 0;
    bit  idle_on = 1'b1;
    bit  hold_req = 1'b0;
    int  noise_base = 1000;
    logic [SBITS-1:0] last_sample = '0;

    t_detect     predicted;
    t_detect     oldest;
    t_detect     observed;
    t_sample_tag cur_tag;

    function automatic int active_len();
        if (len_reg == 0) return 1;
        if (len_reg > WMAX) return WMAX;
        return int'(len_reg);
    endfunction

    task automatic ordered_insert(input int cnt, input logic [SBITS-1:0] v);
        int pos;
        int i;
        pos = 0;
        while (pos < cnt && ordered_win[pos] <= v) pos++;
        for (i = cnt; i > pos; i--) ordered_win[i] = ordered_win[i-1];
        ordered_win[pos] = v;
    endtask

    // drop one entry equal to v, or the last one if none matches
    task automatic ordered_remove(input int cnt, input logic [SBITS-1:0] v);
        int pos;
        int i;
        pos = 0;
        while (pos < cnt && ordered_win[pos] != v) pos++;
        if (pos >= cnt) pos = cnt - 1;
        for (i = pos; i < cnt - 1; i++) ordered_win[i] = ordered_win[i+1];
    endtask

    task automatic median_spike_step(input logic [SBITS-1:0] s, output t_detect r);
        int len;
        int ptr;
        int mid;
        logic [SBITS:0] twice;
        len = active_len();
        ptr = head_idx % len;
        if (fill_cnt < len) begin
            ordered_insert(fill_cnt, s);
            arrival_hist[ptr] = s;
            fill_cnt++;
            head_idx = (ptr + 1) % len;
            r = {1'b0, {(SBITS+1){1'b0}}, 1'b0, spike_total};
        end else begin
            mid = len / 2;
            if (len % 2 == 1)
                twice = {ordered_win[mid], 1'b0};
            else
                twice = {1'b0, ordered_win[mid-1]} + {1'b0, ordered_win[mid]};
            r.full  = 1'b1;
            r.twice = twice;
            r.spike = ({1'b0, s} >= twice);
            if (r.spike && spike_total != COUNT_MAX) spike_total++;
            r.count = spike_total;
            ordered_remove(len, arrival_hist[ptr]);
            ordered_insert(len - 1, s);
            arrival_hist[ptr] = s;
            head_idx = (ptr + 1) % len;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                      n_results, name, got, want));
    endtask

    // monitor: length writes, sample transfers, result transfers
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                len_reg = i_cfg_data;
                fill_cnt = 0;
                head_idx = 0;
                n_len_writes++;
            end
            if (i_valid && o_stall) n_in_stalls++;
            if (i_valid && !o_stall) begin
                cur_tag = sample_tags.pop_front();
                median_spike_step(i_sample_value, predicted);
                pending_results = {pending_results,
                                   (cur_tag.typed ? cur_tag.exp : predicted)};
                n_accepted++;
            end
            if (o_valid && !i_stall) begin
                observed = {o_window_full, o_twice_median, o_spike_flag, o_spike_count};
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing pending",
                                              n_results));
                end else begin
                    oldest = pending_results.pop_front();
                    check_field("window_full", observed.full, oldest.full);
                    check_field("twice_median", observed.twice, oldest.twice);
                    check_field("spike_flag", observed.spike, oldest.spike);
                    check_field("spike_count", observed.count, oldest.count);
                end
                if (observed.full === 1'b1) n_compared++;
                if (observed.spike === 1'b1) n_spikes++;
                n_results++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                             quiet_cycles, n_sent - n_results);
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    // receiver: random stall before each result, or one long hold on request
    initial begin : result_sink
        int unsigned gap;
        wait (i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end else begin
                gap = idle_on ? $urandom_range(0, 19) : 0;
            end
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic send_sample(input logic [SBITS-1:0] v, input bit typed,
                               input t_detect exp);
        t_sample_tag tag;
        int unsigned gap;
        tag.typed = typed;
        tag.exp = exp;
        gap = idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sample_tags = {sample_tags, tag};
        i_valid <= 1'b1;
        i_sample_value <= v;
        do @(posedge i_clk); while (o_stall);
        n_sent++;
        last_sample = v;
    endtask

    // hold the input until every transfer so far has produced its result
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (n_results != n_sent) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [CFG_W-1:0] v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input t_row_kind kind, input logic [SBITS-1:0] value,
                           input bit typed, input logic full, input logic [SBITS:0] twice,
                           input logic spike, input logic [COUNT_W-1:0] count);
        t_stim_row r;
        r.kind = kind;
        r.value = value;
        r.typed = typed;
        r.exp = {full, twice, spike, count};
        stim_rows = {stim_rows, r};
    endtask

    function automatic logic [SBITS-1:0] pick_sample();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom_range(0, 65535);
            4, 5, 6, 7, 8: begin
                v = noise_base + $urandom_range(0, noise_base / 4 + 1);
                // push an occasional sample just past twice the baseline
                if ($urandom_range(0, 7) == 0) v = 2 * noise_base + $urandom_range(0, 200);
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: v = 0;
                    1: v = 65535;
                    2: v = last_sample;
                    default: v = 2 * noise_base;
                endcase
            end
        endcase
        if (v > 65535) v = 65535;
        return v[SBITS-1:0];
    endfunction

    function automatic logic [CFG_W-1:0] pick_length(input int phase);
        logic [CFG_W-1:0] corner [7];
        corner = '{7'd0, 7'd1, 7'd2, 7'd63, 7'd64, 7'd65, 7'd127};
        if (phase < 7) return corner[phase];
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: return CFG_W'($urandom_range(1, 16));
            7, 8: return CFG_W'($urandom_range(0, 127));
            default: return corner[$urandom_range(0, 6)];
        endcase
    endfunction

    initial begin : stimulus
        int phase;
        int n_items;
        int k;
        int len_eff;
        int max_len;
        bit pause_mid;
        logic [CFG_W-1:0] len_code;
        t_detect none;

        none = '0;
        max_len = 1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // length 1 after reset: first sample loads, then each compares with the last one
        add_row(ROW_SAMPLE, 16'd0,     1, 1'b0, 17'd0,      1'b0, 32'd0);
        add_row(ROW_SAMPLE, 16'd0,     1, 1'b1, 17'd0,      1'b1, 32'd1);
        add_row(ROW_SAMPLE, 16'd65535, 1, 1'b1, 17'd0,      1'b1, 32'd2);
        add_row(ROW_SAMPLE, 16'd0,     1, 1'b1, 17'd131070, 1'b0, 32'd2);
        // length code 0 acts as 1; the write empties the window
        add_row(ROW_LENGTH, 16'd0,     0, 1'b0, 17'd0,      1'b0, 32'd0);
        add_row(ROW_SAMPLE, 16'd40000, 1, 1'b0, 17'd0,      1'b0, 32'd2);
        add_row(ROW_SAMPLE, 16'd20000, 1, 1'b1, 17'd80000,  1'b0, 32'd2);
        // even length: threshold is the sum of the two middle entries
        add_row(ROW_LENGTH, 16'd2,     0, 1'b0, 17'd0,      1'b0, 32'd0);
        add_row(ROW_SAMPLE, 16'd100,   1, 1'b0, 17'd0,      1'b0, 32'd2);
        add_row(ROW_SAMPLE, 16'd300,   1, 1'b0, 17'd0,      1'b0, 32'd2);
        add_row(ROW_SAMPLE, 16'd399,   1, 1'b1, 17'd400,    1'b0, 32'd2);
        add_row(ROW_SAMPLE, 16'd700,   1, 1'b1, 17'd699,    1'b1, 32'd3);
        // odd length: a sample exactly at twice the middle entry counts
        add_row(ROW_LENGTH, 16'd3,     0, 1'b0, 17'd0,      1'b0, 32'd0);
        add_row(ROW_SAMPLE, 16'd5,     1, 1'b0, 17'd0,      1'b0, 32'd3);
        add_row(ROW_SAMPLE, 16'd1,     1, 1'b0, 17'd0,      1'b0, 32'd3);
        add_row(ROW_SAMPLE, 16'd9,     1, 1'b0, 17'd0,      1'b0, 32'd3);
        add_row(ROW_SAMPLE, 16'd10,    1, 1'b1, 17'd10,     1'b1, 32'd4);
        add_row(ROW_SAMPLE, 16'd4,     1, 1'b1, 17'd18,     1'b0, 32'd4);
        // duplicates in the window, then the sample extremes
        add_row(ROW_SAMPLE, 16'd9,     0, 1'b0, 17'd0,      1'b0, 32'd0);
        add_row(ROW_SAMPLE, 16'd9,     0, 1'b0, 17'd0,      1'b0, 32'd0);
        add_row(ROW_SAMPLE, 16'd9,     0, 1'b0, 17'd0,      1'b0, 32'd0);
        add_row(ROW_SAMPLE, 16'd65535, 0, 1'b0, 17'd0,      1'b0, 32'd0);
        add_row(ROW_SAMPLE, 16'd0,     0, 1'b0, 17'd0,      1'b0, 32'd0);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_LENGTH)
                write_length(stim_rows[i].value[CFG_W-1:0]);
            else
                send_sample(stim_rows[i].value, stim_rows[i].typed, stim_rows[i].exp);
        end

        phase = 0;
        while (n_sent < ITEM_TARGET) begin
            len_code = pick_length(phase);
            write_length(len_code);
            len_eff = (len_code == 0) ? 1 : (len_code > WMAX) ? WMAX : int'(len_code);
            if (len_eff > max_len) max_len = len_eff;
            noise_base = $urandom_range(0, 30000);
            idle_on = ($urandom_range(0, 3) != 0);
            n_items = len_eff + $urandom_range(20, 70);
            pause_mid = (phase == 1) || ($urandom_range(0, 5) == 0);
            // long receiver hold while samples keep coming
            if (phase == 0 || $urandom_range(0, 7) == 0) begin
                hold_req = 1'b1;
                if (n_items < 80) n_items = 80;
            end
            for (k = 0; k < n_items; k++) begin
                if (pause_mid && k == n_items / 2) wait_drained();
                send_sample(pick_sample(), 1'b0, none);
            end
            phase++;
        end

        wait_drained();
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("Covered %0d samples over %0d length writes (effective lengths up to %0d)",
                 n_accepted, n_len_writes, max_len);
        $display("  %0d full-window comparisons, %0d spikes, %0d cycles of input backpressure",
                 n_compared, n_spikes, n_in_stalls);
        if (err_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("FAIL");
        end
        $finish;
    end

endmodule
